// File: hdl/stbs_pkg.sv
// Shared types and constants for the sorted-table binary search unit.
package stbs_pkg;

  // Action codes carried by an input transaction
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam int SIZE_W  = 9;
  localparam int INDEX_W = 8;
  localparam int VALUE_W = 32;

  typedef struct packed {
    logic                      action;
    logic [INDEX_W-1:0]        load_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic signed [VALUE_W-1:0] target;
  } stbs_in_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] found_index;
  } stbs_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COMPARE,
    ST_DONE
  } stbs_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // write one table entry
    logic init;         // load key and initial bounds
    logic probe;        // read entry at midpoint, latch midpoint
    logic step;         // narrow the bounds after a miss
    logic finish_hit;   // record a match at the latched midpoint
    logic finish_miss;  // record not found
  } stbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range;  // low <= high
    logic hit;       // probed entry equals key
  } stbs_stat_t;

endpackage

// File: hdl/stbs_ctrl.sv
// Controller state machine for the sorted-table binary search unit.
module stbs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               action,
  input  stbs_pkg::stbs_stat_t stat,
  output logic               busy,
  output logic               out_strobe,
  output stbs_pkg::stbs_cmd_t  cmd
);
  import stbs_pkg::*;

  stbs_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && action == ACT_SEARCH) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.in_range) state_nxt = ST_COMPARE;
        else               state_nxt = ST_DONE;
      end
      ST_COMPARE: begin
        if (stat.hit) state_nxt = ST_DONE;
        else          state_nxt = ST_CHECK;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    busy       = 1'b1;
    out_strobe = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.load  = start && action == ACT_LOAD;
        cmd.init  = start && action == ACT_SEARCH;
      end
      ST_CHECK: begin
        cmd.probe       = stat.in_range;
        cmd.finish_miss = !stat.in_range;
      end
      ST_COMPARE: begin
        cmd.finish_hit = stat.hit;
        cmd.step       = !stat.hit;
      end
      ST_DONE: begin
        out_strobe = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: hdl/stbs_datapath.sv
// Table memory, search bounds, key and result registers.
module stbs_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            cfg_we,
  input  logic [stbs_pkg::SIZE_W-1:0]     cfg_data,
  input  logic                            rst_n,
  input  stbs_pkg::stbs_in_t              in_data,
  input  stbs_pkg::stbs_cmd_t             cmd,
  output stbs_pkg::stbs_stat_t            stat,
  output stbs_pkg::stbs_out_t             out_data
);
  import stbs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int BW = AW + 2;  // signed bounds: -1 .. TABLE_DEPTH

  logic [VALUE_W-1:0]        mem [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;
  logic signed [VALUE_W-1:0] key_r;
  logic signed [BW-1:0]      low_r, low_nxt;
  logic signed [BW-1:0]      high_r, high_nxt;
  logic signed [BW-1:0]      mid_r;
  logic signed [BW-1:0]      mid_w;
  logic signed [BW-1:0]      size_eff;
  logic [SIZE_W-1:0]         table_size_r;
  logic                      found_r;
  logic [INDEX_W-1:0]        found_index_r;
  logic [31:0]               load_ext;
  logic [31:0]               size_ext;
  logic [31:0]               mid_ext;
  logic [BW-1:0]             span;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= '0;
    end else if (cfg_we) begin
      table_size_r <= cfg_data;
    end
  end

  // Clamp the size to the table depth
  always_comb begin
    size_ext = 32'(table_size_r);
    if (size_ext > 32'(TABLE_DEPTH)) size_eff = BW'(TABLE_DEPTH);
    else                             size_eff = BW'(size_ext);
  end

  // Midpoint, floor of half the span
  always_comb begin
    span  = BW'(high_r - low_r);
    mid_w = low_r + $signed(span >> 1);
  end

  assign stat.in_range = (low_r <= high_r);
  assign stat.hit      = (rd_data_r == key_r);

  // Table writes; loads beyond the depth are dropped
  assign load_ext = 32'(in_data.load_index);
  always_ff @(posedge clk) begin
    if (cmd.load && load_ext < 32'(TABLE_DEPTH)) begin
      mem[load_ext[AW-1:0]] <= in_data.entry_value;
    end
  end

  // Registered table read at the midpoint
  always_ff @(posedge clk) begin
    if (cmd.probe) begin
      rd_data_r <= mem[mid_w[AW-1:0]];
    end
  end

  // Bound update
  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    priority if (cmd.init) begin
      low_nxt  = '0;
      high_nxt = size_eff - BW'(1);
    end else if (cmd.step) begin
      if (rd_data_r < key_r) low_nxt  = mid_r + BW'(1);
      else                   high_nxt = mid_r - BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  // Key and midpoint
  always_ff @(posedge clk) begin
    if (cmd.init)  key_r <= in_data.target;
    if (cmd.probe) mid_r <= mid_w;
  end

  // Result registers
  assign mid_ext = 32'(mid_r);
  always_ff @(posedge clk) begin
    if (cmd.finish_hit) begin
      found_r       <= 1'b1;
      found_index_r <= mid_ext[INDEX_W-1:0];
    end else if (cmd.finish_miss) begin
      found_r       <= 1'b0;
      found_index_r <= '0;
    end
  end

  assign out_data.found       = found_r;
  assign out_data.found_index = found_index_r;

endmodule

// File: hdl/sorted_table_binary_search_unit.sv
// Top level of the sorted-table binary search unit.
// Software loads signed entries in ascending order (action load, one entry per
// transaction, taken with no result) and sets table_size through
// cfg_we/cfg_data while the unit is idle. A search transaction runs a binary
// search over entries 0..min(table_size, TABLE_DEPTH)-1 with probes at
// low+(high-low)/2 and returns one result: found and found_index, strobed by
// out_strobe for exactly one cycle. The receiver cannot stall; sample the
// result on the strobe. Each probe is a midpoint and registered memory read
// step, then a compare step; a miss ends with a final range check, and every
// search ends with the result strobe. busy is high during a search; the next
// transaction is taken when it drops. Entries read before they were loaded
// return arbitrary data.
module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  stbs_pkg::stbs_in_t           in_data,
  output logic                         out_strobe,
  output stbs_pkg::stbs_out_t          out_data,
  input  logic                         cfg_we,
  input  logic [stbs_pkg::SIZE_W-1:0]  cfg_data
);
  import stbs_pkg::*;

  stbs_cmd_t  cmd;
  stbs_stat_t stat;

  stbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .action     (in_data.action),
    .stat       (stat),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// File: tb/sv/sorted_table_binary_search_unit_test.sv
// Self-checking testbench for the sorted-table binary search unit.
`timescale 1ns / 100ps

module sorted_table_binary_search_unit_test;
  import stbs_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE       = 25;     // longest search plus margin
  localparam int RANDOM_ITEMS = 1550;
  localparam int DEPTH        = 256;
  localparam int MIN_VAL      = 32'sh8000_0000;
  localparam int MAX_VAL      = 32'sh7fff_ffff;
  localparam int PLAN_ROWS    = 25;

  typedef enum logic [1:0] {ROW_LOAD, ROW_SEARCH, ROW_SIZE} row_kind_t;

  // value is the entry for a load, the target for a search, the size for a size write
  typedef struct {
    row_kind_t  kind;
    logic [7:0] index;
    int         value;
    bit         typed;
    stbs_out_t  answer;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  stbs_in_t            in_data;
  logic                out_strobe;
  stbs_out_t           out_data;
  logic                cfg_we;
  logic [SIZE_W-1:0]   cfg_data;

  // Predictor state
  logic signed [VALUE_W-1:0] table_copy [DEPTH];
  logic [SIZE_W-1:0]         size_reg;
  stbs_out_t                 pending_answers [$];

  int  fail_count;
  int  cycle_count;
  int  sent_items;
  int  search_count;
  int  hit_count;
  int  load_count;
  int  size_writes;
  bit  no_idle;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_SEARCH, 8'd0,   0,       1'b1, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   MIN_VAL, 1'b1, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   MAX_VAL, 1'b1, '{1'b0, 8'd0}},
    '{ROW_LOAD,   8'd0,   MIN_VAL, 1'b0, '{1'b0, 8'd0}},
    '{ROW_LOAD,   8'd1,   -5,      1'b0, '{1'b0, 8'd0}},
    '{ROW_LOAD,   8'd2,   7,       1'b0, '{1'b0, 8'd0}},
    '{ROW_LOAD,   8'd3,   MAX_VAL, 1'b0, '{1'b0, 8'd0}},
    '{ROW_LOAD,   8'd255, MAX_VAL, 1'b0, '{1'b0, 8'd0}},
    '{ROW_SIZE,   8'd0,   4,       1'b0, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   MIN_VAL, 1'b0, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   MAX_VAL, 1'b0, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   -5,      1'b0, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   0,       1'b0, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   7,       1'b0, '{1'b0, 8'd0}},
    // duplicate entries at 1 and 2
    '{ROW_LOAD,   8'd1,   7,       1'b0, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   7,       1'b0, '{1'b0, 8'd0}},
    '{ROW_SIZE,   8'd0,   1,       1'b0, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   MIN_VAL, 1'b0, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   MAX_VAL, 1'b0, '{1'b0, 8'd0}},
    // break the ordering, probe sequence still has to match
    '{ROW_LOAD,   8'd2,   -100,    1'b0, '{1'b0, 8'd0}},
    '{ROW_SIZE,   8'd0,   3,       1'b0, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   -100,    1'b0, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   7,       1'b0, '{1'b0, 8'd0}},
    // empty table again
    '{ROW_SIZE,   8'd0,   0,       1'b0, '{1'b0, 8'd0}},
    '{ROW_SEARCH, 8'd0,   MIN_VAL, 1'b1, '{1'b0, 8'd0}}
  };

  sorted_table_binary_search_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Binary search over the shadow table, probe for probe
  function automatic stbs_out_t lookup_answer(input logic signed [VALUE_W-1:0] key);
    int        lo;
    int        hi;
    int        mid;
    stbs_out_t r;
    r  = '0;
    lo = 0;
    hi = ((size_reg > DEPTH) ? DEPTH : int'(size_reg)) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_copy[mid] == key) begin
        r.found       = 1'b1;
        r.found_index = mid[INDEX_W-1:0];
        return r;
      end else if (table_copy[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  // Unused fields are randomized so every input bit toggles
  function automatic stbs_in_t load_txn(input logic [7:0] idx, input int v);
    stbs_in_t t;
    t.action      = ACT_LOAD;
    t.load_index  = idx;
    t.entry_value = v;
    t.target      = $urandom;
    return t;
  endfunction

  function automatic stbs_in_t search_txn(input int key);
    stbs_in_t t;
    t.action      = ACT_SEARCH;
    t.load_index  = INDEX_W'($urandom);
    t.entry_value = $urandom;
    t.target      = key;
    return t;
  endfunction

  // Drive one transaction, wait for acceptance, update the predictor
  task automatic send_txn(input stbs_in_t t, input bit typed, input stbs_out_t answer);
    int        gap;
    stbs_out_t want;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= t;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sent_items++;
    if (t.action == ACT_SEARCH) begin
      want = typed ? answer : lookup_answer(t.target);
      pending_answers.push_back(want);
      search_count++;
      if (want.found) hit_count++;
    end else begin
      table_copy[t.load_index] = t.entry_value;
      load_count++;
    end
  endtask

  // Hold off until every outstanding search has answered
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    size_reg = v;
    size_writes++;
  endtask

  // Load entries 0..n-1 in shuffled order; mostly sorted, sometimes with dups or extremes
  task automatic fill_table(input int n);
    int vals [$];
    int order [$];
    int style;
    int v;
    style = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: v = $urandom;
        1: v = int'($urandom_range(0, n)) - n / 2;
        2: v = $urandom_range(0, 1) ? MIN_VAL + int'($urandom_range(0, 3))
                                    : MAX_VAL - int'($urandom_range(0, 3));
        default: v = $urandom;
      endcase
      vals.push_back(v);
      order.push_back(i);
    end
    if (style != 3 || $urandom_range(0, 1)) vals.sort();
    if (n >= 2 && $urandom_range(0, 2) == 0) begin
      vals[0]     = MIN_VAL;
      vals[n - 1] = MAX_VAL;
    end
    order.shuffle();
    foreach (order[k]) send_txn(load_txn(order[k][7:0], vals[order[k]]), 1'b0, '0);
  endtask

  // Result checker: the receiver never stalls, so every strobe is a transaction
  always @(posedge clk) begin
    stbs_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_answers.size() == 0) begin
        $error("result with no search outstanding: found=%0b found_index=%0d",
               out_data.found, out_data.found_index);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_data.found !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, out_data.found);
          fail_count++;
        end
        if (out_data.found_index !== want.found_index) begin
          $error("found_index: expected %0d, actual %0d", want.found_index,
                 out_data.found_index);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int        dir_items;
    int        phase;
    int        size;
    int        n;
    int        n_search;
    int        key;
    int        idx;
    int        size_plan [7];
    stbs_out_t blank;
    size_plan   = '{256, 511, 1, 2, 0, 300, 3};
    blank       = '0;
    fail_count  = 0;
    cycle_count = 0;
    sent_items  = 0;
    search_count = 0;
    hit_count   = 0;
    load_count  = 0;
    size_writes = 0;
    no_idle     = 1'b0;
    size_reg    = '0;
    foreach (table_copy[i]) table_copy[i] = '0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    foreach (directed_plan[r]) begin
      case (directed_plan[r].kind)
        ROW_SIZE:
          write_size(directed_plan[r].value[SIZE_W-1:0]);
        ROW_LOAD:
          send_txn(load_txn(directed_plan[r].index, directed_plan[r].value), 1'b0, blank);
        default:
          send_txn(search_txn(directed_plan[r].value), directed_plan[r].typed,
                   directed_plan[r].answer);
      endcase
    end
    dir_items = sent_items;

    // Random phases: new size, fresh table, then mostly searches
    phase = 0;
    while (sent_items - dir_items < RANDOM_ITEMS) begin
      if (phase < 7) size = size_plan[phase];
      else if ($urandom_range(0, 7) == 0) size = $urandom_range(41, 511);
      else size = $urandom_range(0, 40);
      no_idle = ($urandom_range(0, 3) == 0);
      write_size(size[SIZE_W-1:0]);
      n = (size > DEPTH) ? DEPTH : size;
      fill_table(n);
      n_search = $urandom_range(15, 50);
      for (int k = 0; k < n_search; k++) begin
        if (k == n_search / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
          wait_drained();
        if ($urandom_range(0, 7) == 0) begin
          // stray load: rewrite an entry, occasionally breaking the order
          idx = $urandom_range(0, DEPTH - 1);
          key = (idx < n && $urandom_range(0, 3) != 0) ? int'(table_copy[idx]) : $urandom;
          send_txn(load_txn(idx[7:0], key), 1'b0, blank);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: key = (n > 0) ? int'(table_copy[$urandom_range(0, n - 1)])
                                         : $urandom;
            5, 6: key = (n > 0) ? int'(table_copy[$urandom_range(0, n - 1)])
                                  + ($urandom_range(0, 1) ? 1 : -1)
                                : $urandom;
            7: key = $urandom_range(0, 1) ? MIN_VAL : MAX_VAL;
            default: key = $urandom;
          endcase
          send_txn(search_txn(key), 1'b0, blank);
        end
      end
      phase++;
    end

    // Drain and let the block settle
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d expected results never arrived", pending_answers.size());
      fail_count++;
    end

    $display("Covered %0d transactions (%0d loads, %0d searches, %0d hits) over %0d phases",
             sent_items, load_count, search_count, hit_count, phase);
    $display("Table size was written %0d times, including 0, 1, 256 and 511", size_writes);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
